@@ src/pbr_pkg.sv @@
// Shared types and constants for the page buffer rasterizer.
package pbr_pkg;

  localparam int unsigned COLUMNS_DEF   = 128;
  localparam int unsigned PAGES_DEF     = 4;
  localparam int unsigned ROWS_PER_PAGE = 8;
  localparam int unsigned BUF_DEPTH     = 128;
  localparam int unsigned GROUP_COLS    = 4;
  localparam int unsigned GROUPS        = BUF_DEPTH / GROUP_COLS;
  localparam int unsigned GROUP_W       = $clog2(GROUPS);

  typedef enum logic [2:0] {
    OP_PIXEL   = 3'd0,
    OP_HLINE   = 3'd1,
    OP_VLINE   = 3'd2,
    OP_RECT    = 3'd3,
    OP_BOX     = 3'd4,
    OP_RESTART = 3'd5,
    OP_FLUSH   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_FLUSH
  } state_e;

  // Draw job broadcast to every column cell.
  typedef struct packed {
    logic [7:0] x;          // left column
    logic [7:0] x_edge;     // right edge column of a rect, wrapped
    logic [8:0] span_end;   // first column past the span, unwrapped
    logic [7:0] span_rows;  // rows set in every column of the span
    logic [7:0] x_rows;     // rows set in column x
    logic [7:0] edge_rows;  // rows set in column x_edge
  } draw_t;

endpackage

@@ src/pbr_decode.sv @@
// Command decoder: turns one draw beat into row masks for the current page.
module pbr_decode
  import pbr_pkg::*;
(
  input  logic [2:0] operation_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [7:0] width_i,
  input  logic [7:0] height_i,
  input  logic [7:0] page_i,
  output draw_t      draw_o
);

  logic       page_ok;
  logic [7:0] y_edge;
  logic [7:0] row_y;
  logic [7:0] row_y_edge;
  logic [7:0] row_run;
  logic [7:0] row_abs;
  logic [7:0] row_off;

  // Only pages below 32 hold rows of an 8-bit row number.
  assign page_ok = (page_i[7:5] == 3'b000);
  assign y_edge  = 8'(y_i + height_i - 8'd1);

  always_comb begin
    row_y      = '0;
    row_y_edge = '0;
    row_run    = '0;
    row_abs    = '0;
    row_off    = '0;
    if (page_ok && (y_i[7:3] == page_i[4:0])) row_y[y_i[2:0]] = 1'b1;
    if (page_ok && (y_edge[7:3] == page_i[4:0])) row_y_edge[y_edge[2:0]] = 1'b1;
    // Vertical run wraps at row 256: test each row's offset from y.
    for (int r = 0; r < 8; r++) begin
      row_abs    = {page_i[4:0], 3'(r)};
      row_off    = 8'(row_abs - y_i);
      row_run[r] = page_ok && (row_off < height_i);
    end
  end

  always_comb begin
    draw_o.x         = x_i;
    draw_o.x_edge    = 8'(x_i + width_i - 8'd1);
    draw_o.span_end  = {1'b0, x_i} + {1'b0, width_i};
    draw_o.span_rows = '0;
    draw_o.x_rows    = '0;
    draw_o.edge_rows = '0;
    unique case (op_e'(operation_i))
      OP_PIXEL: draw_o.x_rows    = row_y;
      OP_HLINE: draw_o.span_rows = row_y;
      OP_VLINE: draw_o.x_rows    = row_run;
      OP_RECT: begin
        draw_o.span_rows = row_y | row_y_edge;
        draw_o.x_rows    = row_run;
        draw_o.edge_rows = row_run;
      end
      OP_BOX:   draw_o.span_rows = row_run;
      default: begin
        draw_o.span_rows = '0;
      end
    endcase
  end

endmodule

@@ src/pbr_cell.sv @@
// One column cell: holds a column byte, ORs in draws, shifts during flush.
module pbr_cell
  import pbr_pkg::*;
#(
  parameter int unsigned COL_INDEX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  draw_t      draw_i,
  input  logic       draw_en_i,
  input  logic       shift_en_i,
  input  logic [7:0] shift_data_i,
  output logic [7:0] col_data_o
);

  localparam logic [8:0] Col = 9'(COL_INDEX);

  logic [7:0] col_q, col_d;
  logic       in_span;
  logic [7:0] set_rows;

  assign in_span  = (Col >= {1'b0, draw_i.x}) && (Col < draw_i.span_end);
  assign set_rows = (in_span ? draw_i.span_rows : 8'h00)
                  | ((Col[7:0] == draw_i.x) ? draw_i.x_rows : 8'h00)
                  | ((Col[7:0] == draw_i.x_edge) ? draw_i.edge_rows : 8'h00);

  always_comb begin
    col_d = col_q;
    if (shift_en_i) begin
      col_d = shift_data_i;
    end else if (draw_en_i) begin
      col_d = col_q | set_rows;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_data_o = col_q;

endmodule

@@ src/page_buffer_rasterizer.sv @@
// Top level: page buffered monochrome rasterizer built on a chain of column cells.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------------
//  command  | valid_i, stall_o | operation_i, x_i, y_i, width_i, height_i
//  groups   | valid_o, stall_i | column_bytes_o, group_index_o, page_number_o,
//           |                  | last_of_page_o, more_pages_o
//
//  Draw commands decode into row masks, then all cells OR at once.
//  Restart and the undefined code finish in the accepting beat.
//  Flush: after the accepting beat, the chain shifts four columns per beat toward
//  the output register, unless the output beat is stalled, for all 32 groups, and
//  zeros shift in behind, clearing the page.
//  Reset clears the buffer and the page counter at once; no startup sweep.
//  stall_i holds the flush stream; stall_o stays high while a command is at work.
module page_buffer_rasterizer
  import pbr_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned PAGES   = PAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [2:0]          operation_i,
  input  logic [7:0]          x_i,
  input  logic [7:0]          y_i,
  input  logic [7:0]          width_i,
  input  logic [7:0]          height_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [31:0]         column_bytes_o,
  output logic [GROUP_W-1:0]  group_index_o,
  output logic [7:0]          page_number_o,
  output logic                last_of_page_o,
  output logic                more_pages_o
);

  state_e state_q, state_d;
  logic [GROUP_W-1:0] group_q;
  logic [7:0]         page_q;
  draw_t              draw_q, draw_d;
  logic               out_valid_q;
  logic [31:0]        out_bytes_q;
  logic [GROUP_W-1:0] out_group_q;
  logic [7:0]         out_page_q;
  logic               out_last_q;
  logic               out_more_q;

  logic       in_fire;
  logic       load;
  logic       last_group;
  logic       draw_en;
  logic [7:0] page_next;
  logic [7:0] col_w [BUF_DEPTH];

  assign in_fire    = valid_i && !stall_o;
  assign load       = (state_q == ST_FLUSH) && (!out_valid_q || !stall_i);
  assign last_group = (group_q == GROUP_W'(GROUPS - 1));
  assign page_next  = 8'(page_q + 8'd1);

  pbr_decode u_decode (
    .operation_i (operation_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .width_i     (width_i),
    .height_i    (height_i),
    .page_i      (page_q),
    .draw_o      (draw_d)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (op_e'(operation_i)) inside
            OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT, OP_BOX: state_d = ST_DRAW;
            OP_FLUSH: state_d = ST_FLUSH;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_DRAW:  state_d = ST_IDLE;
      ST_FLUSH: if (load && last_group) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    stall_o = 1'b1;
    draw_en = 1'b0;
    unique case (state_q)
      ST_IDLE:  stall_o = 1'b0;
      ST_DRAW:  draw_en = 1'b1;
      ST_FLUSH: stall_o = 1'b1;
      default:  stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      group_q     <= '0;
      page_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && (op_e'(operation_i) == OP_RESTART)) begin
        page_q <= '0;
      end else if (load && last_group) begin
        page_q <= page_next;
      end
      if (load) begin
        group_q <= GROUP_W'(group_q + 1'b1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      draw_q <= draw_d;
    end
    if (load) begin
      out_bytes_q <= {col_w[3], col_w[2], col_w[1], col_w[0]};
      out_group_q <= group_q;
      out_page_q  <= page_q;
      out_last_q  <= last_group;
      out_more_q  <= (page_next != 8'(PAGES));
    end
  end

  // Column chain: cell i takes cell i+4 on each flush beat; zeros enter at the far end.
  for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_col
    if (i < COLUMNS) begin : g_cell
      logic [7:0] shift_in;
      if (i + GROUP_COLS < COLUMNS) begin : g_link
        assign shift_in = col_w[i + GROUP_COLS];
      end else begin : g_end
        assign shift_in = 8'h00;
      end
      pbr_cell #(
        .COL_INDEX (i)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .draw_i       (draw_q),
        .draw_en_i    (draw_en),
        .shift_en_i   (load),
        .shift_data_i (shift_in),
        .col_data_o   (col_w[i])
      );
    end else begin : g_none
      assign col_w[i] = 8'h00;
    end
  end

  assign valid_o        = out_valid_q;
  assign column_bytes_o = out_bytes_q;
  assign group_index_o  = out_group_q;
  assign page_number_o  = out_page_q;
  assign last_of_page_o = out_last_q;
  assign more_pages_o   = out_more_q;

endmodule

@@ src/pbr_checker.sv @@
// Port level checks for the page buffer rasterizer, bound to the top level.
module pbr_checker
  import pbr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               stall_o,
  input logic               valid_o,
  input logic               stall_i,
  input logic [31:0]        column_bytes_o,
  input logic [GROUP_W-1:0] group_index_o,
  input logic [7:0]         page_number_o,
  input logic               last_of_page_o
);

  // A stalled beat stays.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(column_bytes_o) && $stable(group_index_o))
    else $error("output beat changed under stall");

  // Groups of one page follow back to back, in order, on the same page.
  a_group_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !last_of_page_o |=>
      valid_o && (group_index_o == GROUP_W'($past(group_index_o) + 1'b1))
      && (page_number_o == $past(page_number_o)))
    else $error("flush groups out of sequence");

  // Last marker sits on the final group only.
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_of_page_o == (group_index_o == GROUP_W'(GROUPS - 1))))
    else $error("last marker on wrong group");

  // No command enters while a page is still streaming.
  a_cmd_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_of_page_o |-> stall_o)
    else $error("command accepted during flush");

endmodule

bind page_buffer_rasterizer pbr_checker u_pbr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .stall_o        (stall_o),
  .valid_o        (valid_o),
  .stall_i        (stall_i),
  .column_bytes_o (column_bytes_o),
  .group_index_o  (group_index_o),
  .page_number_o  (page_number_o),
  .last_of_page_o (last_of_page_o)
);

@@ tb/sv/page_buffer_checker.sv @@
// Checker: predicts the flushed page groups from the command beats and compares them.
module page_buffer_checker
  import pbr_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned PAGES   = PAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  logic               cmd_stall_i,
  input  logic [2:0]         operation_i,
  input  logic [7:0]         x_i,
  input  logic [7:0]         y_i,
  input  logic [7:0]         width_i,
  input  logic [7:0]         height_i,
  input  logic               beat_valid_i,
  input  logic               beat_stall_i,
  input  logic [31:0]        column_bytes_i,
  input  logic [GROUP_W-1:0] group_index_i,
  input  logic [7:0]         page_number_i,
  input  logic               last_of_page_i,
  input  logic               more_pages_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [31:0]        cols;
    logic [GROUP_W-1:0] index;
    logic [7:0]         page;
    logic               last;
    logic               more;
  } group_beat_t;

  logic [7:0]  shadow_buf [BUF_DEPTH];
  logic [7:0]  shadow_page;
  group_beat_t expected_groups [$];
  int          mismatches = 0;

  function automatic void plot(int col, int row);
    row = row & 255;
    if (row / ROWS_PER_PAGE != shadow_page) return;
    if (col >= COLUMNS || col >= BUF_DEPTH) return;
    shadow_buf[col][row % ROWS_PER_PAGE] = 1'b1;
  endfunction

  // Columns run unwrapped; anything past the last column just falls off.
  function automatic void draw_span(int x, int y, int w);
    y = y & 255;
    if (y / ROWS_PER_PAGE != shadow_page) return;
    for (int i = 0; i < w; i++) plot(x + i, y);
  endfunction

  function automatic void draw_column(int x, int y, int h);
    for (int i = 0; i < h; i++) plot(x, (y + i) & 255);
  endfunction

  function automatic void rasterize_command(logic [2:0] op, int x, int y, int w, int h);
    logic [7:0]  next_page;
    group_beat_t beat;
    case (op)
      OP_PIXEL: plot(x, y);
      OP_HLINE: draw_span(x, y, w);
      OP_VLINE: draw_column(x, y, h);
      OP_RECT: begin
        draw_span(x, y, w);
        draw_span(x, (y + h - 1) & 255, w);
        draw_column(x, y, h);
        draw_column((x + w - 1) & 255, y, h);
      end
      OP_BOX: begin
        for (int j = 0; j < h; j++) draw_span(x, (y + j) & 255, w);
      end
      OP_RESTART: shadow_page = '0;
      OP_FLUSH: begin
        next_page = shadow_page + 8'd1;
        for (int g = 0; g < GROUPS; g++) begin
          beat.cols  = {shadow_buf[GROUP_COLS*g+3], shadow_buf[GROUP_COLS*g+2],
                        shadow_buf[GROUP_COLS*g+1], shadow_buf[GROUP_COLS*g]};
          beat.index = GROUP_W'(g);
          beat.page  = shadow_page;
          beat.last  = (g == GROUPS - 1);
          beat.more  = (next_page != PAGES);
          expected_groups.push_back(beat);
        end
        shadow_page = next_page;
        foreach (shadow_buf[c]) shadow_buf[c] = '0;
      end
      default: ;  // undefined code: drop
    endcase
  endfunction

  function automatic void check_beat(group_beat_t got);
    group_beat_t want;
    if (expected_groups.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("group beat with none expected: cols=%h idx=%0d page=%0d last=%b more=%b",
                 got.cols, got.index, got.page, got.last, got.more);
      return;
    end
    want = expected_groups.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"group mismatch: exp cols=%h idx=%0d page=%0d last=%b more=%b,",
                  " got cols=%h idx=%0d page=%0d last=%b more=%b"},
                 want.cols, want.index, want.page, want.last, want.more,
                 got.cols, got.index, got.page, got.last, got.more);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shadow_buf[c]) shadow_buf[c] = '0;
      shadow_page = '0;
      expected_groups.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (beat_valid_i && !beat_stall_i)
        check_beat(group_beat_t'({column_bytes_i, group_index_i, page_number_i,
                                  last_of_page_i, more_pages_i}));
      if (cmd_valid_i && !cmd_stall_i)
        rasterize_command(operation_i, x_i, y_i, width_i, height_i);
      fail_count_o <= mismatches;
      pending_o    <= expected_groups.size();
    end
  end

endmodule

@@ tb/sv/tb_page_buffer_rasterizer.sv @@
// Testbench top: drives draw and flush commands into the rasterizer and gives the verdict.
module tb_page_buffer_rasterizer
  import pbr_pkg::*;
;

  localparam logic [2:0] OP_UNDEFINED = 3'd7;
  localparam int         CYCLE_LIMIT  = 600000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic [2:0]         operation_i;
  logic [7:0]         x_i;
  logic [7:0]         y_i;
  logic [7:0]         width_i;
  logic [7:0]         height_i;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [31:0]        column_bytes_o;
  logic [GROUP_W-1:0] group_index_o;
  logic [7:0]         page_number_o;
  logic               last_of_page_o;
  logic               more_pages_o;

  int         fail_count;
  int         pending;
  logic       quiet;
  logic [7:0] aim_page;
  int         stall_left = 0;
  int         cycle_count = 0;

  page_buffer_rasterizer dut (.*);

  page_buffer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (valid_i),
    .cmd_stall_i    (stall_o),
    .operation_i    (operation_i),
    .x_i            (x_i),
    .y_i            (y_i),
    .width_i        (width_i),
    .height_i       (height_i),
    .beat_valid_i   (valid_o),
    .beat_stall_i   (stall_i),
    .column_bytes_i (column_bytes_o),
    .group_index_i  (group_index_o),
    .page_number_i  (page_number_o),
    .last_of_page_i (last_of_page_o),
    .more_pages_i   (more_pages_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_i    <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_i <= 1'b0;
      if (!quiet && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 14);
    end
  end

  task automatic send_cmd(logic [2:0] op, logic [7:0] x, y, w, h);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    operation_i <= op;
    x_i         <= x;
    y_i         <= y;
    width_i     <= w;
    height_i    <= h;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    if (op == OP_FLUSH) aim_page = aim_page + 8'd1;
    else if (op == OP_RESTART) aim_page = '0;
  endtask

  // Hold the sender until every predicted group beat has come out.
  task automatic wait_drained();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random_mix();
    int         pick;
    logic [2:0] op;
    logic [7:0] x, y, w, h;
    pick = $urandom_range(0, 99);
    x    = 8'($urandom_range(0, 140));
    y    = 8'(int'(aim_page) * 8 + $urandom_range(0, 15) - 4);
    w    = 8'($urandom_range(0, 24));
    h    = 8'($urandom_range(0, 12));
    op   = 3'($urandom_range(OP_PIXEL, OP_BOX));
    if (pick < 10) begin
      op = 3'($urandom);
      x  = 8'($urandom);
      y  = 8'($urandom);
      w  = 8'($urandom);
      h  = 8'($urandom);
    end else if (pick < 14) begin
      op = OP_RESTART;
    end else if (pick < 26) begin
      op = OP_FLUSH;
    end else if (pick < 34) begin
      w = 8'($urandom);  // wide spans run past the last column
    end
    send_cmd(op, x, y, w, h);
    if (op == OP_FLUSH && $urandom_range(0, 5) == 0) wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    valid_i     = 1'b0;
    operation_i = '0;
    x_i         = '0;
    y_i         = '0;
    width_i     = '0;
    height_i    = '0;
    quiet       = 1'b0;
    aim_page    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edges of the page and the columns, wraps, empty shapes.
    send_cmd(OP_PIXEL,   8'd0,   8'd0,   8'd0,   8'd0);
    send_cmd(OP_PIXEL,   8'd127, 8'd7,   8'hff,  8'hff);
    send_cmd(OP_PIXEL,   8'd128, 8'd3,   8'd0,   8'd0);
    send_cmd(OP_PIXEL,   8'd255, 8'd255, 8'd0,   8'd0);
    send_cmd(OP_HLINE,   8'd120, 8'd2,   8'd20,  8'd0);
    send_cmd(OP_HLINE,   8'd255, 8'd4,   8'd255, 8'd0);
    send_cmd(OP_HLINE,   8'd5,   8'd5,   8'd0,   8'd9);
    send_cmd(OP_VLINE,   8'd10,  8'd250, 8'd0,   8'd20);
    send_cmd(OP_VLINE,   8'd11,  8'd0,   8'd7,   8'd0);
    send_cmd(OP_RECT,    8'd20,  8'd1,   8'd0,   8'd0);
    send_cmd(OP_RECT,    8'd30,  8'd2,   8'd5,   8'd4);
    send_cmd(OP_RECT,    8'd0,   8'd0,   8'd1,   8'd1);
    send_cmd(OP_RECT,    8'd126, 8'd6,   8'd255, 8'd255);
    send_cmd(OP_BOX,     8'd40,  8'd3,   8'd8,   8'd3);
    send_cmd(OP_BOX,     8'd50,  8'd0,   8'd0,   8'd5);
    send_cmd(OP_UNDEFINED, 8'hff, 8'hff, 8'hff,  8'hff);
    send_cmd(OP_FLUSH,   8'd0,   8'd0,   8'd0,   8'd0);
    send_cmd(OP_BOX,     8'd0,   8'd0,   8'd255, 8'd255);
    send_cmd(OP_FLUSH,   8'hff,  8'hff,  8'hff,  8'hff);
    send_cmd(OP_PIXEL,   8'd3,   8'd16,  8'd0,   8'd0);
    send_cmd(OP_FLUSH,   8'd0,   8'd0,   8'd0,   8'd0);
    send_cmd(OP_PIXEL,   8'd0,   8'd24,  8'd0,   8'd0);
    send_cmd(OP_FLUSH,   8'd0,   8'd0,   8'd0,   8'd0);
    send_cmd(OP_PIXEL,   8'd5,   8'd32,  8'd0,   8'd0);
    send_cmd(OP_RESTART, 8'd0,   8'd0,   8'd0,   8'd0);
    send_cmd(OP_FLUSH,   8'd0,   8'd0,   8'd0,   8'd0);
    wait_drained();

    repeat (113) send_random_mix();

    // Walk the page counter all the way round, drawing on every reachable page.
    send_cmd(OP_RESTART, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    for (int p = 0; p < 258; p++) begin
      if (p >= 220) quiet = 1'b1;
      if (p < 32)
        send_cmd(3'($urandom_range(OP_PIXEL, OP_BOX)), 8'($urandom_range(0, 135)),
                 8'(p * 8 + $urandom_range(0, 7)), 8'($urandom_range(0, 30)),
                 8'($urandom_range(0, 10)));
      send_cmd(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
